[sv/clrw_pkg.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// clrw_pkg
// Shared types and constants for the column log-ratio weight converter.
// -----------------------------------------------------------------------------
package clrw_pkg;

  localparam int COUNT_W    = 16;
  localparam int MAX_ROWS   = 16;
  localparam int ROW_W      = 4;
  localparam int WEIGHT_W   = 16;
  localparam int COL_W      = 16;
  localparam int LOG_W      = 25;
  localparam int ROWS_MONO  = 4;
  localparam int ROWS_DI    = 16;
  localparam logic [31:0] LN2_Q32 = 32'd2977044472;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [COUNT_W-1:0] maxv;
    logic [ROW_W-1:0]   row;
    logic [COL_W-1:0]   col;
    logic               last;
  } clrw_job_t;

  typedef struct packed {
    logic [WEIGHT_W-1:0] weight;
    logic [ROW_W-1:0]    row;
    logic [COL_W-1:0]    col;
    logic                last;
  } clrw_res_t;

endpackage

[sv/clrw_front.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// clrw_front
// Collects the counts of one column in a double-buffered store, tracks the
// maximum, and hands out one job per row once the column is complete.
// -----------------------------------------------------------------------------
module clrw_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_dinucleotide_mode,
  input  logic                            in_push,
  input  logic [clrw_pkg::COUNT_W-1:0]    in_count,
  output logic                            in_full,
  output logic                            job_valid,
  output clrw_pkg::clrw_job_t             job,
  input  logic                            job_ready
);
  import clrw_pkg::*;

  logic [COUNT_W-1:0] store_r [2*MAX_ROWS];
  logic [COUNT_W-1:0] max_r, max_nxt, emax_r;
  logic [ROW_W:0]     fill_r, held;
  logic               bank_r, ebank_r, busy_r;
  logic [ROW_W:0]     ecnt_r, eidx_r;
  logic [COL_W-1:0]   col_r;
  logic [ROW_W:0]     rows;
  logic               acc, close, emit, wclose;
  logic [COUNT_W-1:0] rd_r;
  logic [ROW_W-1:0]   rrow_r;
  logic               rval_r, rlast_r;
  logic [COL_W-1:0]   rcol_r;
  logic [COUNT_W-1:0] rmax_r;

  assign rows    = cfg_dinucleotide_mode ? (ROW_W+1)'(ROWS_DI) : (ROW_W+1)'(ROWS_MONO);
  assign held    = fill_r + 1'b1;
  assign wclose  = held >= rows || held >= (ROW_W+1)'(MAX_ROWS);
  assign in_full = busy_r && ((ecnt_r - eidx_r > (ROW_W+1)'(1)) || (wclose && !emit));
  assign acc     = in_push && !in_full;
  assign close   = acc && wclose;
  assign max_nxt = (in_count > max_r) ? in_count : max_r;
  assign emit    = busy_r && (!rval_r || job_ready);

  always_ff @(posedge clk) begin
    if (acc) begin
      store_r[{bank_r, fill_r[ROW_W-1:0]}] <= in_count;
    end
    if (emit) begin
      rd_r    <= store_r[{ebank_r, eidx_r[ROW_W-1:0]}];
      rrow_r  <= eidx_r[ROW_W-1:0];
      rlast_r <= (eidx_r + 1'b1 == ecnt_r);
      rcol_r  <= col_r - 1'b1;
      rmax_r  <= emax_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r  <= '0;
      fill_r <= '0;
      bank_r <= 1'b0;
      busy_r <= 1'b0;
      col_r  <= '0;
      rval_r <= 1'b0;
      ecnt_r <= '0;
      eidx_r <= '0;
      ebank_r <= 1'b0;
      emax_r <= '0;
    end else begin
      if (job_ready) begin
        rval_r <= 1'b0;
      end
      if (emit) begin
        rval_r <= 1'b1;
        eidx_r <= eidx_r + 1'b1;
        if (eidx_r + 1'b1 == ecnt_r && !close) begin
          busy_r <= 1'b0;
        end
      end
      if (acc) begin
        if (close) begin
          max_r   <= '0;
          fill_r  <= '0;
          bank_r  <= ~bank_r;
          col_r   <= col_r + 1'b1;
          busy_r  <= 1'b1;
          ecnt_r  <= held;
          eidx_r  <= '0;
          ebank_r <= bank_r;
          emax_r  <= max_nxt;
        end else begin
          max_r  <= max_nxt;
          fill_r <= held;
        end
      end
    end
  end

  assign job_valid = rval_r;
  assign job.count = rd_r;
  assign job.maxv  = rmax_r;
  assign job.row   = rrow_r;
  assign job.col   = rcol_r;
  assign job.last  = rlast_r;

endmodule

[sv/clrw_log2.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// clrw_log2
// Iterative log2 in Q.20 by repeated squaring, one fraction bit per cycle.
// -----------------------------------------------------------------------------
module clrw_log2 (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [clrw_pkg::COUNT_W:0]    val,
  output logic                          done,
  output logic [clrw_pkg::LOG_W-1:0]    result
);
  import clrw_pkg::*;

  logic [32:0] m_r;
  logic [63:0] sq;
  logic [32:0] msq;
  logic [19:0] f_r;
  logic [4:0]  e_r, k_r, e_c;
  logic        run_r;
  logic [31:0] norm;

  always_comb begin
    e_c = '0;
    for (int i = 0; i <= COUNT_W; i++) begin
      if (val[i]) begin
        e_c = 5'(i);
      end
    end
    norm = 32'({15'd0, val}) << (5'd31 - e_c);
  end

  assign sq  = 64'(m_r) * 64'(m_r);
  assign msq = 33'(sq >> 31);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      done  <= 1'b0;
      k_r   <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        k_r   <= '0;
        m_r   <= {1'b0, norm};
        e_r   <= e_c;
        f_r   <= '0;
      end else if (run_r) begin
        f_r <= {f_r[18:0], msq[32]};
        m_r <= msq[32] ? (msq >> 1) : msq;
        k_r <= k_r + 1'b1;
        if (k_r == 5'd19) begin
          run_r <= 1'b0;
          done  <= 1'b1;
        end
      end
    end
  end

  assign result = {e_r, f_r};

endmodule

[sv/clrw_back.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// clrw_back
// Computes one weight per job from the two logarithms and holds the result
// in a two-entry output queue.
// -----------------------------------------------------------------------------
module clrw_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      job_valid,
  input  clrw_pkg::clrw_job_t       job,
  output logic                      job_ready,
  output logic                      out_empty,
  input  logic                      out_pop,
  output clrw_pkg::clrw_res_t       res
);
  import clrw_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_LOG, S_MUL, S_DONE} state_t;

  state_t              state_r;
  clrw_job_t           job_r;
  logic                lstart, dx, dy;
  logic [LOG_W-1:0]    lx, ly, d_r;
  logic [57:0]         prod_r;
  logic [16:0]         n;
  logic [WEIGHT_W-1:0] w;
  clrw_res_t           q_r [2];
  logic                wp_r, rp_r;
  logic [1:0]          cnt_r;
  logic                push, pop;

  assign job_ready = (state_r == S_IDLE);
  assign lstart    = job_valid && job_ready;

  clrw_log2 u_lx (.clk, .rst_n, .start(lstart), .val({job.count, 1'b1}),
                  .done(dx), .result(lx));
  clrw_log2 u_ly (.clk, .rst_n, .start(lstart), .val({job.maxv, 1'b1}),
                  .done(dy), .result(ly));

  assign n    = (prod_r[57:41] > 17'd32768) ? 17'd32768 : prod_r[57:41];
  assign w    = WEIGHT_W'(17'h10000 - n);
  assign push = (state_r == S_DONE) && cnt_r != 2'd2;
  assign pop  = out_pop && cnt_r != 2'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: if (lstart) begin
          job_r   <= job;
          state_r <= S_LOG;
        end
        S_LOG: if (dx && dy) begin
          d_r     <= (ly > lx) ? ly - lx : '0;
          state_r <= S_MUL;
        end
        S_MUL: begin
          prod_r  <= 58'(d_r) * 58'(LN2_Q32) + (58'd1 << 40);
          state_r <= S_DONE;
        end
        S_DONE: if (push) begin
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
      if (push) begin
        q_r[wp_r] <= '{weight: w, row: job_r.row, col: job_r.col, last: job_r.last};
        wp_r <= ~wp_r;
      end
      if (pop) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  assign out_empty = (cnt_r == 2'd0);
  assign res       = q_r[rp_r];

endmodule

[sv/column_log_ratio_weights.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// column_log_ratio_weights
// Converts frequency counts to Berg and von Hippel log-ratio weights.
// -----------------------------------------------------------------------------
// Counts are accepted at most one per cycle into a double-buffered column
// store. While more than one weight of the previous column still waits to be
// handed to the back end, in_full holds the input off, and the count that
// closes a column also waits until the last weight of the previous column has
// been handed over. Each weight is 0x10000 minus the rounded value of
// 2048*ln((max+0.5)/(count+0.5)), clamped at 32768, and is worked out in a
// shared pair of iterative log2 units: a start, twenty squaring steps, then
// subtract, multiply and queue. The back end takes one job at a time.
module column_log_ratio_weights (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  logic        in_push,
  input  logic [15:0] in_count,
  output logic        in_full,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [15:0] out_weight,
  output logic [3:0]  out_row_index,
  output logic [15:0] out_column_number,
  output logic        out_last_of_column
);
  import clrw_pkg::*;

  logic      mode_r;
  logic      job_valid, job_ready;
  clrw_job_t job;
  clrw_res_t res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
    end else if (cfg_we) begin
      mode_r <= cfg_wdata;
    end
  end

  clrw_front u_front (.clk, .rst_n, .cfg_dinucleotide_mode(mode_r), .in_push,
                      .in_count, .in_full, .job_valid, .job, .job_ready);
  clrw_back u_back (.clk, .rst_n, .job_valid, .job, .job_ready, .out_empty,
                    .out_pop, .res);

  assign out_weight         = res.weight;
  assign out_row_index      = res.row;
  assign out_column_number  = res.col;
  assign out_last_of_column = res.last;

endmodule

[test/tb_column_log_ratio_weights.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb_column_log_ratio_weights
// Self-checking testbench for the column log-ratio weight converter.
// -----------------------------------------------------------------------------
// Counts are pushed as requests with random gaps, and results are popped with
// random stalls, including one long stall that fills the block. A scoreboard
// predicts each column's weights from the accepted counts and compares every
// popped result field by field. Both row modes are exercised, and the mode is
// also switched in the middle of a column.
module tb_column_log_ratio_weights;
  import clrw_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 500;

  class weight_scoreboard;
    logic [COUNT_W-1:0] held_counts[MAX_ROWS];
    logic [COUNT_W-1:0] col_max;
    int                 held;
    logic [COL_W-1:0]   col_num;
    logic               dinuc;
    clrw_res_t          expected_q[$];
    int                 errors;

    function new();
      col_max = '0;
      held = 0;
      col_num = '0;
      dinuc = 1'b0;
      errors = 0;
    endfunction

    function bit [63:0] log2_q20(bit [63:0] v);
      int e;
      bit [63:0] m;
      bit [63:0] f;
      e = 0;
      f = 0;
      if (v == 0) v = 1;
      for (int k = 63; k > 0; k--) begin
        if (v[k]) begin
          e = k;
          break;
        end
      end
      m = (e <= 31) ? (v << (31 - e)) : (v >> (e - 31));
      for (int k = 0; k < 20; k++) begin
        m = (m * m) >> 31;
        f = f << 1;
        if ((m >> 32) != 0) begin
          f = f | 64'd1;
          m = m >> 1;
        end
      end
      return (64'(e) << 20) | f;
    endfunction

    function logic [WEIGHT_W-1:0] weight_of(logic [COUNT_W-1:0] c, logic [COUNT_W-1:0] mx);
      bit [63:0] lx;
      bit [63:0] ly;
      bit [63:0] d;
      bit [63:0] n;
      lx = log2_q20(2 * 64'(c) + 1);
      ly = log2_q20(2 * 64'(mx) + 1);
      d = (ly > lx) ? ly - lx : 64'd0;
      n = (d * 64'(LN2_Q32) + (64'd1 << 40)) >> 41;
      if (n > 32768) n = 32768;
      return 16'(64'h10000 - n);
    endfunction

    function void note_count(logic [COUNT_W-1:0] c);
      int rows;
      clrw_res_t r;
      rows = dinuc ? ROWS_DI : ROWS_MONO;
      held_counts[held] = c;
      if (c > col_max) col_max = c;
      held++;
      if (held < rows && held < MAX_ROWS) return;
      for (int i = 0; i < held; i++) begin
        r.weight = weight_of(held_counts[i], col_max);
        r.row = ROW_W'(i);
        r.col = col_num;
        r.last = (i + 1 == held);
        expected_q.push_back(r);
      end
      held = 0;
      col_max = '0;
      col_num = col_num + 1'b1;
    endfunction

    function void check_result(clrw_res_t got);
      clrw_res_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result weight=%h row=%0d col=%0d last=%b", $time,
                 got.weight, got.row, got.col, got.last);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got.weight !== want.weight) begin
        $display("%0t: weight expected %h actual %h", $time, want.weight, got.weight);
        errors++;
      end
      if (got.row !== want.row) begin
        $display("%0t: row_index expected %0d actual %0d", $time, want.row, got.row);
        errors++;
      end
      if (got.col !== want.col) begin
        $display("%0t: column_number expected %0d actual %0d", $time, want.col, got.col);
        errors++;
      end
      if (got.last !== want.last) begin
        $display("%0t: last_of_column expected %b actual %b", $time, want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic        cfg_wdata;
  logic        in_push;
  logic [15:0] in_count;
  logic        in_full;
  logic        out_empty;
  logic        out_pop;
  logic [15:0] out_weight;
  logic [3:0]  out_row_index;
  logic [15:0] out_column_number;
  logic        out_last_of_column;

  weight_scoreboard sb;
  int  cycle_count;
  int  hold_request;
  bit  send_burst;
  bit  pop_burst;
  int  items_sent;

  column_log_ratio_weights DUT (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_push(in_push),
    .in_count(in_count),
    .in_full(in_full),
    .out_empty(out_empty),
    .out_pop(out_pop),
    .out_weight(out_weight),
    .out_row_index(out_row_index),
    .out_column_number(out_column_number),
    .out_last_of_column(out_last_of_column)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    cycle_count = 0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic push_count(logic [15:0] c);
    int gap;
    gap = send_burst ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push <= 1'b1;
    in_count <= c;
    do @(posedge clk); while (in_full);
    sb.note_count(c);
    items_sent++;
  endtask

  task automatic wait_drained();
    in_push <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(logic v);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.dinuc = v;
  endtask

  function automatic logic [15:0] random_count();
    case ($urandom_range(0, 5))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(0, 15));
      3: return 16'($urandom_range(65000, 65535));
      default: return 16'($urandom);
    endcase
  endfunction

  // Result side: random stalls, plus a long hold when the sender asks for it.
  initial begin
    int gap;
    out_pop = 1'b0;
    hold_request = 0;
    pop_burst = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      gap = pop_burst ? 0 : $urandom_range(0, 11);
      if (hold_request > 0 || gap > 0) begin
        out_pop <= 1'b0;
        repeat (hold_request + gap) @(posedge clk);
        hold_request = 0;
      end
      out_pop <= 1'b1;
      do @(posedge clk); while (out_empty);
      sb.check_result('{out_weight, out_row_index, out_column_number, out_last_of_column});
    end
  end

  initial begin
    logic mode;
    int ncols;
    sb = new();
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = 1'b0;
    in_push = 1'b0;
    in_count = '0;
    send_burst = 1'b0;
    items_sent = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: equal counts, extremes, sixteen-row column, mid-column mode changes.
    for (int i = 0; i < 4; i++) push_count(16'd0);
    push_count(16'hFFFF); push_count(16'd0); push_count(16'd1); push_count(16'hFFFF);
    write_mode(1'b1);
    for (int i = 0; i < 16; i++) push_count(16'(1 << i) - 16'(i & 1));
    write_mode(1'b0);
    push_count(16'd7); push_count(16'd300);
    write_mode(1'b1);
    for (int i = 0; i < 14; i++) push_count(random_count());
    push_count(16'd5); push_count(16'hFFFF); push_count(16'd0);
    write_mode(1'b0);
    push_count(16'd12);

    // Long stall on the result side while requests keep coming.
    write_mode(1'b1);
    hold_request = 400;
    send_burst = 1'b1;
    for (int i = 0; i < 48; i++) push_count(random_count());
    send_burst = 1'b0;

    while (items_sent < 445) begin
      mode = 1'($urandom_range(0, 1));
      write_mode(mode);
      send_burst = ($urandom_range(0, 3) == 0);
      pop_burst = ($urandom_range(0, 3) == 0);
      ncols = $urandom_range(2, 8);
      for (int i = 0; i < ncols * (mode ? ROWS_DI : ROWS_MONO); i++)
        push_count(random_count());
      if ($urandom_range(0, 2) == 0) begin
        for (int i = 0; i < $urandom_range(1, 3); i++) push_count(random_count());
      end
    end
    send_burst = 1'b0;
    pop_burst = 1'b0;

    wait_drained();
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
